[rtl/pftgm_pkg.sv]
// ----------------------------------------------------------------------------
// pftgm_pkg: shared constants of the traffic gap monitor
// Table sizes, status and kind codes, register indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package pftgm_pkg;
   localparam int FLOW_ENTRIES    = 64;
   localparam int SESSION_ENTRIES = 64;
   localparam int FLOW_IDX_W      = $clog2(FLOW_ENTRIES);
   localparam int SESS_IDX_W      = $clog2(SESSION_ENTRIES);
   localparam int KEY_W           = 49;

   localparam logic [1:0] KIND_ADDRESSED = 2'd0;
   localparam logic [1:0] KIND_AGGREGATE = 2'd1;
   localparam logic [1:0] KIND_SESSION   = 2'd2;

   localparam logic [2:0] ST_DISABLED   = 3'd0;
   localparam logic [2:0] ST_ZERO_LEN   = 3'd1;
   localparam logic [2:0] ST_SESS_OFF   = 3'd2;
   localparam logic [2:0] ST_CREATED    = 3'd3;
   localparam logic [2:0] ST_UPDATED    = 3'd4;
   localparam logic [2:0] ST_SESS_WRITE = 3'd5;
   localparam logic [2:0] ST_SESS_FULL  = 3'd6;

   localparam logic [0:0] REG_CAPTURE   = 1'd0;
   localparam logic [0:0] REG_THRESHOLD = 1'd1;

   localparam logic [31:0] RESET_THRESHOLD = 32'd100000000;
endpackage
`default_nettype wire

[rtl/pftgm_csr.sv]
// ----------------------------------------------------------------------------
// pftgm_csr: configuration registers
// APB-style write/read of capture enable and stall threshold.
// ----------------------------------------------------------------------------
`default_nettype none
module pftgm_csr
   import pftgm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             capture_enable,
   output logic [31:0]      stall_threshold_ns
);
   logic        cap_ff, cap_in;
   logic [31:0] thr_ff, thr_in;
   logic        wr;

   assign wr = psel && penable && pwrite;

   always_comb begin
      cap_in = cap_ff;
      thr_in = thr_ff;
      if (wr && paddr[1:0] == 2'b00) begin
         case (paddr[2])
            REG_CAPTURE:   cap_in = pwdata[0];
            REG_THRESHOLD: thr_in = pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= 1'b0;
         thr_ff <= RESET_THRESHOLD;
      end else begin
         cap_ff <= cap_in;
         thr_ff <= thr_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[1:0] == 2'b00) begin
         case (paddr[2])
            REG_CAPTURE:   prdata = {31'd0, cap_ff};
            REG_THRESHOLD: prdata = thr_ff;
            default:       prdata = '0;
         endcase
      end
   end

   assign capture_enable     = cap_ff;
   assign stall_threshold_ns = thr_ff;
endmodule
`default_nettype wire

[rtl/per_flow_traffic_gap_monitor_unit.sv]
// ----------------------------------------------------------------------------
// per_flow_traffic_gap_monitor_unit: per-flow traffic statistics
// Sequential scan of session and flow tables with a shared compare unit.
// ----------------------------------------------------------------------------
// One item at a time. A single key comparator walks the session table and then
// the flow table, one entry a cycle from registered table reads. A flow hit
// adds a table read (S_RD) and 64-bit update arithmetic in S_UPD1 and S_UPD2.
// A final pass rewrites the recency ranks. Aggregate packets skip the session
// pass. A session write, or a packet whose session is absent, ends after the
// session pass. An item that is ignored at once goes straight to S_OUT.
// Exactly one result per item is shown for one cycle on rsp_valid, in the
// first cycle with busy low. The next item can be taken at the edge that ends
// that cycle. The receiver cannot stall. After reset, busy is high while the
// rank table is loaded. Write configuration through the csr_ port only while
// busy is low. Flow and session valid bits are cleared at reset.
`default_nettype none
module per_flow_traffic_gap_monitor_unit
   import pftgm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_kind,
   input  wire logic [47:0] req_device_address,
   input  wire logic        req_direction,
   input  wire logic [15:0] req_byte_count,
   input  wire logic [63:0] req_timestamp_ns,
   input  wire logic        req_session_enable,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [63:0]      rsp_total_bytes,
   output logic [63:0]      rsp_total_packets,
   output logic [63:0]      rsp_stall_count,
   output logic [63:0]      rsp_largest_gap_ns,
   output logic             rsp_stall_seen,
   output logic             rsp_entry_evicted,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SSCAN = 4'd1;
   localparam logic [3:0] S_FSCAN = 4'd2;
   localparam logic [3:0] S_RD    = 4'd3;
   localparam logic [3:0] S_UPD1  = 4'd4;
   localparam logic [3:0] S_UPD2  = 4'd5;
   localparam logic [3:0] S_RANK  = 4'd6;
   localparam logic [3:0] S_OUT   = 4'd7;
   localparam logic [3:0] S_LRU   = 4'd8;
   localparam logic [3:0] S_INIT  = 4'd9;

   logic        cap_en;
   logic [31:0] thr;

   pftgm_csr u_csr (
      .clock, .reset,
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata),
      .capture_enable(cap_en), .stall_threshold_ns(thr)
   );
   assign csr_pready = 1'b1;

   // storage
   logic [KEY_W-1:0]      skey_mem [SESSION_ENTRIES];
   logic [KEY_W-1:0]      fkey_mem [FLOW_ENTRIES];
   logic [63:0]           byt_mem  [FLOW_ENTRIES];
   logic [63:0]           pkt_mem  [FLOW_ENTRIES];
   logic [63:0]           last_mem [FLOW_ENTRIES];
   logic [63:0]           stl_mem  [FLOW_ENTRIES];
   logic [63:0]           gap_mem  [FLOW_ENTRIES];
   logic [FLOW_IDX_W-1:0] rank_mem [FLOW_ENTRIES];
   logic [SESSION_ENTRIES-1:0] svalid_ff;
   logic [FLOW_ENTRIES-1:0]    fvalid_ff;

   logic [3:0]            state_ff;
   logic [1:0]            kind_ff;
   logic [KEY_W-1:0]      key_ff;
   logic [15:0]           len_ff;
   logic [63:0]           now_ff;
   logic                  en_ff;
   logic [SESS_IDX_W:0]   sidx_ff;
   logic [FLOW_IDX_W:0]   fidx_ff;
   logic                  shit_ff;
   logic [SESS_IDX_W-1:0] shitidx_ff, sfree_ff;
   logic                  sfree_v_ff;
   logic                  fhit_ff, ffree_v_ff, evict_ff;
   logic [FLOW_IDX_W-1:0] ent_ff, ffree_ff, lru_ff;
   logic [FLOW_IDX_W-1:0] myrank_ff, frank_ff;
   logic [63:0] rb_ff, rp_ff, rl_ff, rs_ff, rg_ff, gapv_ff;
   logic        gapok_ff, stall_ff;
   logic [2:0]  status_ff;
   logic        rsp_v_ff;

   // registered table reads; a scan cycle handles the entry addressed in the
   // cycle before
   logic [KEY_W-1:0]      skey_rd_ff, fkey_rd_ff;
   logic [FLOW_IDX_W-1:0] rank_rd_ff;
   logic [SESS_IDX_W-1:0] sprev;
   logic [FLOW_IDX_W-1:0] fprev;

   assign sprev = sidx_ff[SESS_IDX_W-1:0] - 1'b1;
   assign fprev = fidx_ff[FLOW_IDX_W-1:0] - 1'b1;

   always_ff @(posedge clock) begin
      skey_rd_ff <= skey_mem[sidx_ff[SESS_IDX_W-1:0]];
      fkey_rd_ff <= fkey_mem[fidx_ff[FLOW_IDX_W-1:0]];
      rank_rd_ff <= rank_mem[fidx_ff[FLOW_IDX_W-1:0]];
   end

   // shared key comparator
   logic [KEY_W-1:0] cmp_key;
   logic             cmp_eq;
   always_comb begin
      cmp_key = (state_ff == S_SSCAN) ? skey_rd_ff : fkey_rd_ff;
      cmp_eq  = (cmp_key == key_ff);
   end

   logic [63:0] gap_w;
   assign gap_w = now_ff - rl_ff;

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else begin
         rsp_v_ff <= (state_ff == S_OUT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_INIT;
         fidx_ff   <= '0;
         svalid_ff <= '0;
         fvalid_ff <= '0;
      end else begin
         case (state_ff)
            S_INIT: begin
               // load ranks with the entry index, one entry a cycle
               rank_mem[fidx_ff[FLOW_IDX_W-1:0]] <= fidx_ff[FLOW_IDX_W-1:0];
               if (fidx_ff == (FLOW_IDX_W+1)'(FLOW_ENTRIES - 1)) begin
                  fidx_ff  <= '0;
                  state_ff <= S_IDLE;
               end else fidx_ff <= fidx_ff + 1'b1;
            end
            S_IDLE: begin
               if (start) begin
                  kind_ff <= req_kind;
                  key_ff  <= (req_kind == KIND_AGGREGATE) ? '0
                             : {req_direction, req_device_address};
                  len_ff  <= (req_kind == KIND_AGGREGATE) ? 16'd1 : req_byte_count;
                  now_ff  <= req_timestamp_ns;
                  en_ff   <= req_session_enable;
                  sidx_ff <= '0; fidx_ff <= '0;
                  shit_ff <= 1'b0; sfree_v_ff <= 1'b0;
                  fhit_ff <= 1'b0; ffree_v_ff <= 1'b0; evict_ff <= 1'b0;
                  stall_ff <= 1'b0;
                  if (req_kind == KIND_SESSION) state_ff <= S_SSCAN;
                  else if (req_kind == KIND_ADDRESSED && cap_en && req_byte_count != 0)
                     state_ff <= S_SSCAN;
                  else if (req_kind == KIND_AGGREGATE && cap_en) state_ff <= S_FSCAN;
                  else begin
                     status_ff <= (req_kind == KIND_ADDRESSED && cap_en) ? ST_ZERO_LEN
                                  : ST_DISABLED;
                     state_ff  <= S_OUT;
                  end
               end
            end
            S_SSCAN: begin
               if (sidx_ff != '0) begin
                  if (svalid_ff[sprev]) begin
                     if (cmp_eq && !shit_ff) begin
                        shit_ff <= 1'b1; shitidx_ff <= sprev;
                     end
                  end else if (!sfree_v_ff) begin
                     sfree_v_ff <= 1'b1; sfree_ff <= sprev;
                  end
               end
               if (sidx_ff[SESS_IDX_W]) state_ff <= S_RD; // resolve below
               else sidx_ff <= sidx_ff + 1'b1;
            end
            S_RD: begin
               // session scan finished (or flow scan finished on a hit)
               if (sidx_ff[SESS_IDX_W]) begin
                  sidx_ff <= '0;
                  if (kind_ff == KIND_SESSION) begin
                     status_ff <= ST_SESS_WRITE;
                     if (en_ff) begin
                        if (!shit_ff) begin
                           if (sfree_v_ff) begin
                              svalid_ff[sfree_ff] <= 1'b1;
                              skey_mem[sfree_ff]  <= key_ff;
                           end else status_ff <= ST_SESS_FULL;
                        end
                     end else if (shit_ff) svalid_ff[shitidx_ff] <= 1'b0;
                     state_ff <= S_OUT;
                  end else if (!shit_ff) begin
                     status_ff <= ST_SESS_OFF; state_ff <= S_OUT;
                  end else state_ff <= S_FSCAN;
               end else begin
                  rb_ff <= byt_mem[ent_ff]; rp_ff <= pkt_mem[ent_ff];
                  rl_ff <= last_mem[ent_ff]; rs_ff <= stl_mem[ent_ff];
                  rg_ff <= gap_mem[ent_ff];
                  state_ff <= S_UPD1;
               end
            end
            S_FSCAN: begin
               if (fidx_ff != '0) begin
                  if (fvalid_ff[fprev]) begin
                     if (cmp_eq && !fhit_ff) begin
                        fhit_ff <= 1'b1; ent_ff <= fprev; myrank_ff <= rank_rd_ff;
                     end
                  end else if (!ffree_v_ff) begin
                     ffree_v_ff <= 1'b1; ffree_ff <= fprev; frank_ff <= rank_rd_ff;
                  end
                  if (rank_rd_ff == FLOW_IDX_W'(FLOW_ENTRIES - 1)) lru_ff <= fprev;
               end
               if (fidx_ff[FLOW_IDX_W]) state_ff <= S_LRU;
               else fidx_ff <= fidx_ff + 1'b1;
            end
            S_LRU: begin
               fidx_ff <= '0;
               if (fhit_ff) begin
                  state_ff <= S_RD;
               end else begin
                  if (ffree_v_ff) begin
                     ent_ff <= ffree_ff; myrank_ff <= frank_ff;
                  end else begin
                     ent_ff <= lru_ff; evict_ff <= 1'b1;
                     myrank_ff <= FLOW_IDX_W'(FLOW_ENTRIES - 1);
                  end
                  state_ff <= S_UPD2;
               end
            end
            S_UPD1: begin
               gapok_ff <= (rl_ff != 64'd0) && (now_ff > rl_ff);
               gapv_ff  <= gap_w;
               rb_ff    <= rb_ff + {48'd0, len_ff};
               rp_ff    <= rp_ff + 64'd1;
               state_ff <= S_UPD2;
            end
            S_UPD2: begin
               if (fhit_ff) begin
                  if (gapok_ff && gapv_ff > {32'd0, thr}) begin
                     rs_ff <= rs_ff + 64'd1; stall_ff <= 1'b1;
                  end
                  if (gapok_ff && gapv_ff > rg_ff) rg_ff <= gapv_ff;
                  status_ff <= ST_UPDATED;
               end else begin
                  rb_ff <= {48'd0, len_ff}; rp_ff <= 64'd1;
                  rs_ff <= '0; rg_ff <= '0;
                  fvalid_ff[ent_ff] <= 1'b1;
                  fkey_mem[ent_ff]  <= key_ff;
                  status_ff <= ST_CREATED;
               end
               state_ff <= S_RANK;
            end
            S_RANK: begin
               // one rank entry a cycle; the touched entry gets rank zero
               if (fidx_ff != '0) begin
                  if (fprev == ent_ff)
                     rank_mem[fprev] <= '0;
                  else if (rank_rd_ff < myrank_ff)
                     rank_mem[fprev] <= rank_rd_ff + 1'b1;
               end
               if (fidx_ff[FLOW_IDX_W]) begin
                  byt_mem[ent_ff] <= rb_ff; pkt_mem[ent_ff] <= rp_ff;
                  last_mem[ent_ff] <= now_ff; stl_mem[ent_ff] <= rs_ff;
                  gap_mem[ent_ff] <= rg_ff;
                  state_ff <= S_OUT;
               end else fidx_ff <= fidx_ff + 1'b1;
            end
            S_OUT: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   logic upd;
   assign upd = (status_ff == ST_CREATED) || (status_ff == ST_UPDATED);
   assign rsp_valid          = rsp_v_ff;
   assign rsp_status         = status_ff;
   assign rsp_total_bytes    = upd ? rb_ff : '0;
   assign rsp_total_packets  = upd ? rp_ff : '0;
   assign rsp_stall_count    = upd ? rs_ff : '0;
   assign rsp_largest_gap_ns = upd ? rg_ff : '0;
   assign rsp_stall_seen     = (status_ff == ST_UPDATED) && stall_ff;
   assign rsp_entry_evicted  = (status_ff == ST_CREATED) && evict_ff;

`ifndef SYNTHESIS
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("item not taken");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result repeated");
`endif
endmodule
`default_nettype wire
